FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

FILE: design/pfsa_pkg.sv
// Package with the types, constants and codes of the page frame stack allocator.
`timescale 1ns / 1ps
`default_nettype none

package pfsa_pkg;

	localparam int STACK_DEPTH = 8192;
	localparam int PAGE_BITS   = 12;
	localparam int WORD_W      = 32;
	localparam int FRAME_W     = WORD_W - PAGE_BITS;
	localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
	localparam int SLOT_W      = $clog2(STACK_DEPTH);
	localparam int FREE_W      = 14;
	localparam int TYPE_W      = 8;
	localparam int PADDR_W     = 3;
	localparam logic [TYPE_W-1:0] TYPE_USABLE = TYPE_W'(1);
	localparam logic [TOP_W-1:0]  TOP_FULL    = TOP_W'(STACK_DEPTH);

	typedef enum logic [1:0] {
		FN_ALLOC  = 2'd0,
		FN_FREE   = 2'd1,
		FN_REGION = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// Configuration register index, taken from paddr above the byte offset.
	typedef enum logic {
		REG_KERNEL_END = 1'b0,
		REG_NONE       = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ALLOC,
		BK_REGION
	} back_state_t;

	// Classified request as it travels from the front part to the back part.
	typedef struct packed {
		func_t              op;
		logic [FRAME_W-1:0] frame;
		logic [FRAME_W:0]   rbegin;
		logic [FRAME_W:0]   rend;
	} cmd_t;

endpackage

`default_nettype wire

FILE: design/pfsa_front.sv
// Front part: configuration register and classification of incoming requests.
`timescale 1ns / 1ps
`default_nettype none

module pfsa_front import pfsa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [WORD_W-1:0]  pwdata,
	output logic      [WORD_W-1:0]  prdata,
	input  wire logic [1:0]         func,
	input  wire logic [WORD_W-1:0]  addr,
	input  wire logic [WORD_W-1:0]  length,
	input  wire logic [TYPE_W-1:0]  region_type,
	output cmd_t                    cmd
);

	logic [WORD_W-1:0] kernel_end_q;
	logic [WORD_W-1:0] base_max;
	logic [WORD_W:0]   begin_up;
	logic [WORD_W:0]   end_sum;
	logic [WORD_W:0]   end_sat;
	logic [WORD_W:0]   end_al;
	logic              region_live;
	reg_idx_t          reg_idx;

	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_end_q <= '0;
		end else if (psel && penable && pwrite && reg_idx == REG_KERNEL_END) begin
			kernel_end_q <= pwdata;
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KERNEL_END: prdata = kernel_end_q;
			default:        prdata = '0;
		endcase
	end

	// The usable part of a region starts at the kernel end at the earliest.
	always_comb begin
		base_max = (addr < kernel_end_q) ? kernel_end_q : addr;
		begin_up = {1'b0, base_max} + (WORD_W+1)'((1 << PAGE_BITS) - 1);
		end_sum  = {1'b0, addr} + {1'b0, length};
		end_sat  = end_sum[WORD_W] ? {1'b1, {WORD_W{1'b0}}} : end_sum;
		end_al   = {end_sat[WORD_W:PAGE_BITS], {PAGE_BITS{1'b0}}};
		region_live = (region_type == TYPE_USABLE) && !(end_al < {1'b0, kernel_end_q});
	end

	always_comb begin
		cmd.frame  = addr[WORD_W-1:PAGE_BITS];
		cmd.rbegin = begin_up[WORD_W:PAGE_BITS];
		cmd.rend   = end_sat[WORD_W:PAGE_BITS];
		case (func_t'(func))
			FN_ALLOC:  cmd.op = FN_ALLOC;
			FN_FREE:   cmd.op = FN_FREE;
			FN_REGION: cmd.op = region_live ? FN_REGION : FN_NONE;
			default:   cmd.op = FN_NONE;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/pfsa_queue.sv
// Two-entry request queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module pfsa_queue import pfsa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      nonempty,
	output cmd_t      head
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

FILE: design/pfsa_back.sv
// Back part: the free page stack, its counters and the result register.
`timescale 1ns / 1ps
`default_nettype none

module pfsa_back import pfsa_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [WORD_W-1:0] page_addr,
	output logic [1:0]        status,
	output logic [FREE_W-1:0] free_pages,
	output logic [WORD_W-1:0] total_pages
);

	logic [FRAME_W-1:0] mem [STACK_DEPTH];
	logic [FRAME_W-1:0] rd_q;

	back_state_t        state_q, state_d;
	logic [FRAME_W:0]   begin_q, begin_d;
	logic [FRAME_W:0]   end_q, end_d;
	logic [TOP_W-1:0]   top_q, top_d;
	logic [WORD_W-1:0]  added_q, added_d;

	logic               out_valid_q;
	logic [WORD_W-1:0]  page_q;
	status_t            status_q;
	logic [FREE_W-1:0]  free_q;
	logic [WORD_W-1:0]  total_q;

	logic               can_load;
	logic               load;
	logic [WORD_W-1:0]  res_page;
	status_t            res_status;
	logic               mem_we;
	logic [SLOT_W-1:0]  mem_wa;
	logic [FRAME_W-1:0] mem_wd;
	logic               mem_re;
	logic [SLOT_W-1:0]  mem_ra;
	logic [TOP_W-1:0]   top_dec;
	logic               more;

	assign can_load = !out_valid_q || !out_stall;
	assign top_dec  = top_q - TOP_W'(1);
	assign more     = (begin_q < end_q);

	always_comb begin
		state_d    = state_q;
		begin_d    = begin_q;
		end_d      = end_q;
		top_d      = top_q;
		added_d    = added_q;
		q_pop      = 1'b0;
		load       = 1'b0;
		res_page   = '0;
		res_status = ST_OK;
		mem_we     = 1'b0;
		mem_wa     = top_q[SLOT_W-1:0];
		mem_wd     = q_cmd.frame;
		mem_re     = 1'b0;
		mem_ra     = top_dec[SLOT_W-1:0];
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						FN_ALLOC: begin
							if (top_q == '0) begin
								if (can_load) begin
									q_pop      = 1'b1;
									load       = 1'b1;
									res_status = ST_EMPTY;
								end
							end else begin
								q_pop   = 1'b1;
								mem_re  = 1'b1;
								top_d   = top_dec;
								state_d = BK_ALLOC;
							end
						end
						FN_FREE: begin
							if (can_load) begin
								q_pop = 1'b1;
								load  = 1'b1;
								if (top_q == TOP_FULL) begin
									res_status = ST_FULL;
								end else begin
									mem_we = 1'b1;
									top_d  = top_q + TOP_W'(1);
								end
							end
						end
						FN_REGION: begin
							q_pop   = 1'b1;
							begin_d = q_cmd.rbegin;
							end_d   = q_cmd.rend;
							state_d = BK_REGION;
						end
						default: begin
							if (can_load) begin
								q_pop = 1'b1;
								load  = 1'b1;
							end
						end
					endcase
				end
			end
			BK_ALLOC: begin
				if (can_load) begin
					load     = 1'b1;
					res_page = {rd_q, {PAGE_BITS{1'b0}}};
					state_d  = BK_IDLE;
				end
			end
			BK_REGION: begin
				// One page is pushed per cycle until the region or the stack runs out.
				if (more && top_q != TOP_FULL) begin
					mem_we  = 1'b1;
					mem_wd  = begin_q[FRAME_W-1:0];
					top_d   = top_q + TOP_W'(1);
					begin_d = begin_q + (FRAME_W+1)'(1);
					if (added_q != '1) begin
						added_d = added_q + WORD_W'(1);
					end
				end else if (can_load) begin
					load       = 1'b1;
					res_status = more ? ST_FULL : ST_OK;
					state_d    = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			top_q       <= '0;
			added_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			added_q <= added_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		begin_q <= begin_d;
		end_q   <= end_d;
		if (load) begin
			page_q   <= res_page;
			status_q <= res_status;
			free_q   <= FREE_W'(top_d);
			total_q  <= added_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	assign out_valid   = out_valid_q;
	assign page_addr   = page_q;
	assign status      = status_q;
	assign free_pages  = free_q;
	assign total_pages = total_q;

endmodule

`default_nettype wire

FILE: design/page_frame_stack_allocator.sv
// Top level of the page frame stack allocator.
// Each request gives one result. In the back part, a free, an undefined request, an alloc on
// an empty stack, and an add-region request for memory that is not usable or that ends below
// the kernel end are answered from the idle state. Any other alloc reads the stack in the idle
// state and is answered from the alloc state, as the stack memory has a registered read port.
// Any other add-region request leaves the queue in the idle state, has one page per cycle
// pushed in the region state and then gets its result. The front part classifies requests into
// a two-entry queue, so new requests are taken while the back part is still pushing the pages
// of a region. The stack memory starts with undefined contents and needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_stack_allocator import pfsa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [WORD_W-1:0]  pwdata,
	output logic      [WORD_W-1:0]  prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [WORD_W-1:0]  addr,
	input  wire logic [WORD_W-1:0]  length,
	input  wire logic [TYPE_W-1:0]  region_type,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [WORD_W-1:0]  page_addr,
	output logic      [1:0]         status,
	output logic      [FREE_W-1:0]  free_pages,
	output logic      [WORD_W-1:0]  total_pages
);

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic q_full;
	logic q_nonempty;
	logic q_pop;

	assign pready   = 1'b1;
	assign in_stall = q_full;

	pfsa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.func        (func),
		.addr        (addr),
		.length      (length),
		.region_type (region_type),
		.cmd         (front_cmd)
	);

	pfsa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (head_cmd)
	);

	pfsa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_nonempty),
		.q_cmd       (head_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.page_addr   (page_addr),
		.status      (status),
		.free_pages  (free_pages),
		.total_pages (total_pages)
	);

endmodule

`default_nettype wire

FILE: design/pfsa_checker.sv
// Port-level checker for the page frame stack allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfsa_checker import pfsa_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [WORD_W-1:0] page_addr,
	input wire logic [1:0]        status,
	input wire logic [FREE_W-1:0] free_pages
);

	`ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(page_addr))
	`ASSERT_SAME(a_status_code, clk, arst_n, out_valid, status != ST_RSVD)
	`ASSERT_SAME(a_empty_result, clk, arst_n, out_valid && status == ST_EMPTY, page_addr == '0 && free_pages == '0)
	`ASSERT_SAME(a_page_aligned, clk, arst_n, out_valid, page_addr[PAGE_BITS-1:0] == '0)
	`ASSERT_SAME(a_fill_bound, clk, arst_n, out_valid, free_pages <= FREE_W'(STACK_DEPTH))

endmodule

bind page_frame_stack_allocator pfsa_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.page_addr  (page_addr),
	.status     (status),
	.free_pages (free_pages)
);

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the page frame stack allocator: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;
	import pfsa_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int PHASE_ITEMS  = 220;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [PADDR_W-1:0] KERNEL_END_ADDR = {REG_KERNEL_END, 2'b00};

	typedef struct packed {
		func_t               fn;
		logic [WORD_W-1:0]   addr;
		logic [WORD_W-1:0]   length;
		logic [TYPE_W-1:0]   rtype;
	} page_request_t;

	typedef struct packed {
		logic [WORD_W-1:0]   page_addr;
		status_t             status;
		logic [FREE_W-1:0]   free_pages;
		logic [WORD_W-1:0]   total_pages;
	} page_result_t;

	typedef enum logic {
		ROW_REQUEST,
		ROW_KERNEL_END
	} row_kind_t;

	// A kernel_end row carries the register value in addr.
	typedef struct packed {
		row_kind_t           kind;
		func_t               fn;
		logic [WORD_W-1:0]   addr;
		logic [WORD_W-1:0]   length;
		logic [TYPE_W-1:0]   rtype;
		bit                  typed;
		logic [WORD_W-1:0]   page_addr;
		status_t             status;
		logic [FREE_W-1:0]   free_pages;
		logic [WORD_W-1:0]   total_pages;
	} stim_row_t;

	localparam stim_row_t DIRECTED [27] = '{
		'{ROW_REQUEST, FN_ALLOC, 32'h0, 32'h0, 8'h00, 1'b1, 32'h0, ST_EMPTY, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1,
			32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_REGION, 32'h0, 32'h0001_0000, 8'h00, 1'b1, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_KERNEL_END, FN_NONE, 32'h0000_3001, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_REGION, 32'h0, 32'h0000_6000, 8'h01, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_REGION, 32'h1000, 32'h0000_1000, 8'h01, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_FREE, 32'hABCD_E123, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_ALLOC, 32'h0, 32'h0, 8'h00, 1'b1, 32'hABCD_E000, ST_OK, 14'd2, 32'd2},
		'{ROW_REQUEST, FN_FREE, 32'hFFFF_FFFF, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_ALLOC, 32'h0, 32'h0, 8'h00, 1'b1, 32'hFFFF_F000, ST_OK, 14'd2, 32'd2},
		'{ROW_REQUEST, FN_FREE, 32'h0, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_ALLOC, 32'h0, 32'h0, 8'h00, 1'b1, 32'h0, ST_OK, 14'd2, 32'd2},
		'{ROW_REQUEST, FN_ALLOC, 32'h0, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_ALLOC, 32'h0, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_ALLOC, 32'h0, 32'h0, 8'h00, 1'b1, 32'h0, ST_EMPTY, 14'd0, 32'd2},
		'{ROW_KERNEL_END, FN_NONE, 32'h0, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_REGION, 32'hFFFF_F000, 32'h2000, 8'h01, 1'b0,
			32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_REGION, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h01, 1'b0,
			32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_KERNEL_END, FN_NONE, 32'hFFFF_FFFF, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_REGION, 32'h0, 32'hFFFF_FFFF, 8'h01, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_REGION, 32'hFFFF_F000, 32'h1000, 8'h01, 1'b0,
			32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_KERNEL_END, FN_NONE, 32'hFE00_0000, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_REGION, 32'h0, 32'hFFFF_FFFF, 8'h01, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_FREE, 32'h1234_5000, 32'h0, 8'h00, 1'b1,
			32'h0, ST_FULL, 14'd8192, 32'd8194},
		'{ROW_REQUEST, FN_REGION, 32'hFE00_0000, 32'h2000, 8'h01, 1'b1,
			32'h0, ST_FULL, 14'd8192, 32'd8194},
		'{ROW_REQUEST, FN_ALLOC, 32'h0, 32'h0, 8'h00, 1'b0, 32'h0, ST_OK, 14'd0, 32'd0},
		'{ROW_REQUEST, FN_REGION, 32'hFE10_0000, 32'h3000, 8'h01, 1'b0,
			32'h0, ST_OK, 14'd0, 32'd0}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [WORD_W-1:0]   pwdata;
	logic [WORD_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          func;
	logic [WORD_W-1:0]   addr;
	logic [WORD_W-1:0]   length;
	logic [TYPE_W-1:0]   region_type;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [WORD_W-1:0]   page_addr;
	logic [1:0]          status;
	logic [FREE_W-1:0]   free_pages;
	logic [WORD_W-1:0]   total_pages;

	// Shadow copy of the allocator state.
	logic [FRAME_W-1:0]  frame_stack [STACK_DEPTH];
	int                  stack_level = 0;
	logic [WORD_W-1:0]   region_pages = '0;
	logic [WORD_W-1:0]   kernel_end_shadow = '0;

	page_result_t        awaited_results [$];
	page_result_t        oldest_result;
	int                  err_count = 0;
	int                  cycle_count = 0;
	bit                  steady = 1'b0;

	page_frame_stack_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.addr        (addr),
		.length      (length),
		.region_type (region_type),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.page_addr   (page_addr),
		.status      (status),
		.free_pages  (free_pages),
		.total_pages (total_pages)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit push_frame(input logic [WORD_W-1:0] page);
		if (stack_level >= STACK_DEPTH)
			return 1'b0;
		frame_stack[stack_level] = page[WORD_W-1:PAGE_BITS];
		stack_level++;
		return 1'b1;
	endfunction

	function automatic page_result_t apply_request(input page_request_t rq);
		page_result_t res;
		logic [WORD_W:0] span_lo;
		logic [WORD_W:0] span_hi;
		logic [WORD_W:0] page_size;
		res = '{page_addr: '0, status: ST_OK, free_pages: '0, total_pages: '0};
		page_size = (WORD_W + 1)'(1) << PAGE_BITS;
		case (rq.fn)
			FN_ALLOC: begin
				if (stack_level == 0) begin
					res.status = ST_EMPTY;
				end else begin
					stack_level--;
					res.page_addr = {frame_stack[stack_level], {PAGE_BITS{1'b0}}};
				end
			end
			FN_FREE: begin
				if (!push_frame(rq.addr))
					res.status = ST_FULL;
			end
			FN_REGION: begin
				if (rq.rtype == TYPE_USABLE) begin
					span_lo = (rq.addr < kernel_end_shadow) ? {1'b0, kernel_end_shadow}
						: {1'b0, rq.addr};
					span_lo = (span_lo + page_size - 1) & ~(page_size - 1);
					span_hi = {1'b0, rq.addr} + {1'b0, rq.length};
					// A region running past the top of the address space is cut at 4 GiB.
					if (span_hi > {1'b1, {WORD_W{1'b0}}})
						span_hi = {1'b1, {WORD_W{1'b0}}};
					span_hi = span_hi & ~(page_size - 1);
					if (span_hi >= {1'b0, kernel_end_shadow}) begin
						while (span_lo < span_hi && res.status == ST_OK) begin
							if (!push_frame(span_lo[WORD_W-1:0])) begin
								res.status = ST_FULL;
							end else begin
								span_lo = span_lo + page_size;
								if (region_pages != '1)
									region_pages++;
							end
						end
					end
				end
			end
			default: ;
		endcase
		res.free_pages  = FREE_W'(stack_level);
		res.total_pages = region_pages;
		return res;
	endfunction

	task automatic send_request(input page_request_t rq, input bit typed,
		input page_result_t typed_res);
		page_result_t res;
		if (!steady && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		in_valid    <= 1'b1;
		func        <= rq.fn;
		addr        <= rq.addr;
		length      <= rq.length;
		region_type <= rq.rtype;
		do @(posedge clk); while (in_stall);
		res = apply_request(rq);
		awaited_results.push_back(typed ? typed_res : res);
	endtask

	task automatic apb_transfer(input bit wr, input logic [PADDR_W-1:0] where,
		input logic [WORD_W-1:0] wdata, output logic [WORD_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= where;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rdata = prdata;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_kernel_end(input logic [WORD_W-1:0] value);
		logic [WORD_W-1:0] readback;
		apb_transfer(1'b0, KERNEL_END_ADDR, '0, readback);
		if (readback !== value) begin
			$error("kernel_end: expected %h, got %h", value, readback);
			err_count++;
		end
	endtask

	// The register is only touched once every outstanding request has been answered.
	task automatic set_kernel_end(input logic [WORD_W-1:0] value);
		logic [WORD_W-1:0] unused;
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		apb_transfer(1'b1, KERNEL_END_ADDR, value, unused);
		kernel_end_shadow = value;
		check_kernel_end(value);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result with no request outstanding: page_addr %h status %0d",
					page_addr, status);
				err_count++;
			end else begin
				oldest_result = awaited_results.pop_front();
				if (page_addr !== oldest_result.page_addr) begin
					$error("page_addr: expected %h, got %h", oldest_result.page_addr, page_addr);
					err_count++;
				end
				if (status !== oldest_result.status) begin
					$error("status: expected %0d, got %0d", oldest_result.status, status);
					err_count++;
				end
				if (free_pages !== oldest_result.free_pages) begin
					$error("free_pages: expected %0d, got %0d", oldest_result.free_pages,
						free_pages);
					err_count++;
				end
				if (total_pages !== oldest_result.total_pages) begin
					$error("total_pages: expected %0d, got %0d", oldest_result.total_pages,
						total_pages);
					err_count++;
				end
			end
		end
		out_stall <= !steady && ($urandom_range(99) < 21);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		page_request_t rq;
		page_result_t  typed_res;
		logic [WORD_W-1:0] phase_value;
		int unsigned   roll;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		func        <= FN_NONE;
		addr        <= '0;
		length      <= '0;
		region_type <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		check_kernel_end('0);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_KERNEL_END) begin
				set_kernel_end(DIRECTED[i].addr);
			end else begin
				rq = '{fn: DIRECTED[i].fn, addr: DIRECTED[i].addr,
					length: DIRECTED[i].length, rtype: DIRECTED[i].rtype};
				typed_res = '{page_addr: DIRECTED[i].page_addr, status: DIRECTED[i].status,
					free_pages: DIRECTED[i].free_pages, total_pages: DIRECTED[i].total_pages};
				send_request(rq, DIRECTED[i].typed, typed_res);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_ITEMS == 0) begin
				case (n / PHASE_ITEMS)
					1: phase_value = '0;
					2: phase_value = $urandom_range(0, 32'h0010_0000);
					3: phase_value = '1;
					default: phase_value = $urandom;
				endcase
				set_kernel_end(phase_value);
			end
			steady = (n >= 300 && n < 550);
			rq.addr   = $urandom;
			rq.length = $urandom;
			rq.rtype  = $urandom_range(255);
			roll = $urandom_range(99);
			if (roll < 40) begin
				rq.fn = FN_ALLOC;
			end else if (roll < 72) begin
				rq.fn = FN_FREE;
			end else if (roll < 94) begin
				rq.fn = FN_REGION;
				if ($urandom_range(9) < 7)
					rq.rtype = TYPE_USABLE;
				// Most regions sit near the kernel end and span a few dozen pages at most.
				roll = $urandom_range(19);
				if (roll < 14) begin
					rq.addr   = kernel_end_shadow - 32'h4000 + $urandom_range(0, 32'h1_0000);
					rq.length = ($urandom_range(0, 48) << PAGE_BITS) + $urandom_range(0, 4095);
				end else if (roll < 17) begin
					rq.length = $urandom_range(0, 32'h2_0000);
				end
			end else begin
				rq.fn = FN_NONE;
			end
			send_request(rq, 1'b0, '0);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
